/* rtl/multiscroll_attractor_euler_step_core_macros.svh */
// ----------------------------------------------------------------------------
// multiscroll_attractor_euler_step_core_macros
// Assertion macros for the attractor step core.
// ----------------------------------------------------------------------------
`ifndef MULTISCROLL_ATTRACTOR_EULER_STEP_CORE_MACROS_SVH
`define MULTISCROLL_ATTRACTOR_EULER_STEP_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define MSA_ASSERT_IMPL(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
`define MSA_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`else
`define MSA_ASSERT_IMPL(label, clk, rst_n, cond)
`define MSA_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

/* rtl/msa_pkg.sv */
// ----------------------------------------------------------------------------
// msa_pkg
// Types, constants and register indexes of the attractor step core.
// ----------------------------------------------------------------------------
`default_nettype none
package msa_pkg;
    localparam int unsigned STEP_FRAC     = 20;
    localparam int unsigned LEVEL_LOW     = 655;
    localparam int unsigned LEVEL_SPAN_R  = 41943;
    localparam int unsigned LEVEL_SPAN_GB = 37356;

    typedef enum logic [2:0] {
        REG_STEP_SIZE  = 3'd0,
        REG_SLOW_DECAY = 3'd1,
        REG_LED_COUNT  = 3'd2,
        REG_START_X    = 3'd3,
        REG_START_Y    = 3'd4,
        REG_START_Z    = 3'd5
    } reg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } ctrl_state_t;

    // controller -> datapath
    typedef struct packed {
        logic       start;      // latch input item
        logic       mul_step;   // run one micro step of the arithmetic sequence
        logic       div_start;  // begin divider op
        logic       div_step;   // one restoring step
        logic       div_store;  // store quotient
        logic       commit;     // result taken, return to idle
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic mul_last;
        logic div_last_op;
        logic div_last_bit;
    } dp_status_t;
endpackage
`default_nettype wire

/* rtl/msa_if.sv */
// ----------------------------------------------------------------------------
// msa_if
// Valid/ready channels: input item, result item and register writes.
// ----------------------------------------------------------------------------
`default_nettype none
interface msa_in_if;
    logic               valid;
    logic               ready;
    logic signed [24:0] forcing;
    modport source (output valid, output forcing, input ready);
    modport sink   (input valid, input forcing, output ready);
endinterface

interface msa_out_if;
    logic        valid;
    logic        ready;
    logic [9:0]  red_index;
    logic [9:0]  green_index;
    logic [9:0]  blue_index;
    logic [15:0] red_level;
    logic [15:0] green_level;
    logic [15:0] blue_level;
    logic        saturated;
    modport source (output valid, output red_index, output green_index,
        output blue_index, output red_level, output green_level,
        output blue_level, output saturated, input ready);
    modport sink (input valid, input red_index, input green_index,
        input blue_index, input red_level, input green_level,
        input blue_level, input saturated, output ready);
endinterface

interface msa_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* rtl/multiscroll_attractor_euler_step_core.sv */
// ----------------------------------------------------------------------------
// multiscroll_attractor_euler_step_core
// One Euler step of a multiscroll attractor per tick, mapped to LED outputs.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch   : forcing value, one transaction per tick.
//   out_ch  : three LED indices, three levels and a saturation flag.
//   cfg_ch  : register writes (index, data), taken at any time; write only
//             while idle. Start positions also load the state before the
//             first tick.
//   Sequence: 16 multiply steps on the shared 33x33 multiplier, then six
//             divisions on the one-bit-per-cycle divider; the result is
//             registered after the last division.
//   Occupancy: one item in flight; the next input is taken only after the
//             previous result transaction.
//   Reset   : registers take their documented defaults, trackers clear,
//             the first tick seeds them.
//   Stall   : a result holds in the output register until taken; input
//             stays blocked until that transaction. State updates at the
//             end of the multiply phase.
// ----------------------------------------------------------------------------
`default_nettype none
`include "multiscroll_attractor_euler_step_core_macros.svh"
module multiscroll_attractor_euler_step_core #(
    parameter int unsigned MAX_LEDS  = 1024,
    parameter int unsigned FRAC_BITS = 20
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    msa_in_if.sink     in_ch,
    msa_out_if.source  out_ch,
    msa_cfg_if.sink    cfg_ch
);
    import msa_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;
    logic       busy;
    logic       in_fire;
    logic       out_valid_reg;

    assign in_ch.ready  = !busy;
    assign in_fire      = in_ch.valid && !busy;
    assign cfg_ch.ready = 1'b1;
    assign out_ch.valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.div_store && status.div_last_op)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    msa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .out_free (out_valid_reg && out_ch.ready),
        .status   (status),
        .cmd      (cmd),
        .busy     (busy)
    );

    msa_dp #(
        .MAX_LEDS  (MAX_LEDS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .forcing     (in_ch.forcing),
        .cfg_we      (cfg_ch.valid),
        .cfg_index   (cfg_ch.index),
        .cfg_data    (cfg_ch.data),
        .red_index   (out_ch.red_index),
        .green_index (out_ch.green_index),
        .blue_index  (out_ch.blue_index),
        .red_level   (out_ch.red_level),
        .green_level (out_ch.green_level),
        .blue_level  (out_ch.blue_level),
        .saturated   (out_ch.saturated)
    );

    `MSA_ASSERT_IMPL(a_no_accept_busy, clk, rst_n, !(in_fire && out_valid_reg))
    `MSA_ASSERT_NEXT(a_commit_drops_valid, clk, rst_n, cmd.commit, !out_valid_reg)
    `MSA_ASSERT_IMPL(a_valid_only_busy, clk, rst_n, !out_valid_reg || busy)
endmodule
`default_nettype wire

/* rtl/msa_ctrl.sv */
// ----------------------------------------------------------------------------
// msa_ctrl
// Sequencer: multiply phase, six serial divisions, result handoff.
// ----------------------------------------------------------------------------
`default_nettype none
module msa_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_fire,
    input  wire logic                 out_free,
    input  wire msa_pkg::dp_status_t  status,
    output msa_pkg::ctrl_cmd_t        cmd,
    output logic                      busy
);
    import msa_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        div_run_reg, div_run_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            div_run_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            div_run_reg <= div_run_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        div_run_next = div_run_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (status.mul_last)
                begin
                    state_next   = ST_DIV;
                    div_run_next = 1'b0;
                end
            end
            ST_DIV:
            begin
                if (!div_run_reg)
                    div_run_next = 1'b1;
                else if (status.div_last_bit)
                begin
                    div_run_next = 1'b0;
                    if (status.div_last_op)
                        state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy      = 1'b0;
                cmd.start = in_fire;
            end
            ST_MUL:  cmd.mul_step = 1'b1;
            ST_DIV:
            begin
                cmd.div_start = !div_run_reg;
                cmd.div_step  = div_run_reg;
                cmd.div_store = div_run_reg && status.div_last_bit;
            end
            ST_DONE: cmd.commit = out_free;
            default: ;
        endcase
    end
endmodule
`default_nettype wire

/* rtl/msa_dp.sv */
// ----------------------------------------------------------------------------
// msa_dp
// Datapath: one shared signed multiplier, serial divider, state and trackers.
// ----------------------------------------------------------------------------
`default_nettype none
module msa_dp #(
    parameter int unsigned MAX_LEDS  = 1024,
    parameter int unsigned FRAC_BITS = 20
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire msa_pkg::ctrl_cmd_t cmd,
    output msa_pkg::dp_status_t     status,
    input  wire logic signed [24:0] forcing,
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    output logic [9:0]              red_index,
    output logic [9:0]              green_index,
    output logic [9:0]              blue_index,
    output logic [15:0]             red_level,
    output logic [15:0]             green_level,
    output logic [15:0]             blue_level,
    output logic                    saturated
);
    import msa_pkg::*;

    localparam int unsigned NW = $clog2(MAX_LEDS + 1);
    localparam logic [NW-1:0] NMAX = NW'(MAX_LEDS);
    localparam int unsigned MUL_STEPS = 15;

    // ---------------- configuration and state ----------------
    logic [19:0] step_reg, decay_reg;
    logic [10:0] led_reg;
    logic signed [31:0] startx_reg, starty_reg, startz_reg;
    logic signed [31:0] pos_reg [3];
    logic signed [31:0] min_reg [3];
    logic signed [31:0] max_reg [3];
    logic [31:0]        rate_reg [3];
    logic               first_reg;

    // working registers
    logic signed [24:0] u_reg;
    logic signed [31:0] d_reg [3];
    logic signed [31:0] p_reg [3];
    logic signed [31:0] lo_reg [3];
    logic signed [31:0] hi_reg [3];
    logic [31:0]        r_reg [3];
    logic signed [63:0] prod_reg;
    logic signed [63:0] xz_reg;
    logic               sat_reg;
    logic [3:0]         mstep_reg;
    logic [2:0]         op_reg;
    logic [5:0]         bit_reg;
    logic [63:0]        num_reg;
    logic [32:0]        rem_reg;
    logic [31:0]        den_reg;
    logic [15:0]        q_reg [6];

    logic [NW-1:0] n_eff;
    always_comb
    begin
        if (led_reg == 11'd0)
            n_eff = NW'(1);
        else if (32'(led_reg) > MAX_LEDS)
            n_eff = NMAX;
        else
            n_eff = NW'(led_reg);
    end

    function automatic logic signed [31:0] clip(input logic signed [65:0] v);
        if (v > 66'sh7FFFFFFF)
            return 32'sh7FFFFFFF;
        else if (v < -66'sh80000000)
            return -32'sh80000000;
        else
            return v[31:0];
    endfunction

    function automatic logic ovf(input logic signed [65:0] v);
        return (v > 66'sh7FFFFFFF) || (v < -66'sh80000000);
    endfunction

    function automatic logic [31:0] mag(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

    // ---------------- shared multiplier (one per step) ----------------
    logic signed [32:0] ma, mb;
    logic signed [65:0] mprod;
    always_comb
    begin
        ma = '0;
        mb = '0;
        case (mstep_reg)
            4'd0:  begin ma = 33'(pos_reg[0]); mb = 33'(pos_reg[2]); end
            4'd1:  begin ma = 33'(pos_reg[0]); mb = 33'(pos_reg[1]); end
            4'd3:  begin ma = 33'(d_reg[0]);   mb = 33'($signed({1'b0, step_reg})); end
            4'd4:  begin ma = 33'(d_reg[1]);   mb = 33'($signed({1'b0, step_reg})); end
            4'd5:  begin ma = 33'(d_reg[2]);   mb = 33'($signed({1'b0, step_reg})); end
            4'd6:  begin ma = 33'(min_reg[0]); mb = 33'($signed({1'b0, decay_reg})); end
            4'd7:  begin ma = 33'(min_reg[1]); mb = 33'($signed({1'b0, decay_reg})); end
            4'd8:  begin ma = 33'(min_reg[2]); mb = 33'($signed({1'b0, decay_reg})); end
            4'd9:  begin ma = 33'(max_reg[0]); mb = 33'($signed({1'b0, decay_reg})); end
            4'd10: begin ma = 33'(max_reg[1]); mb = 33'($signed({1'b0, decay_reg})); end
            4'd11: begin ma = 33'(max_reg[2]); mb = 33'($signed({1'b0, decay_reg})); end
            4'd12: begin ma = $signed({1'b0, rate_reg[0]}); mb = 33'($signed({1'b0, decay_reg})); end
            4'd13: begin ma = $signed({1'b0, rate_reg[1]}); mb = 33'($signed({1'b0, decay_reg})); end
            4'd14: begin ma = $signed({1'b0, rate_reg[2]}); mb = 33'($signed({1'b0, decay_reg})); end
            default: ;
        endcase
        mprod = ma * mb;
    end

    // derivative sums (use registered products)
    logic signed [65:0] dx_sum, dy_sum, dz_sum, step_sh;
    logic signed [65:0] pnew;
    always_comb
    begin
        dx_sum = 66'(36) * (66'(pos_reg[1]) - 66'(pos_reg[0]));
        dy_sum = 66'(pos_reg[0]) - 66'(xz_reg) + 66'(20) * 66'(pos_reg[1]) + 66'(u_reg);
        dz_sum = 66'(prod_reg >>> FRAC_BITS) - 66'(3) * 66'(pos_reg[2]);
        step_sh = 66'(prod_reg >>> STEP_FRAC);
        pnew = 66'(pos_reg[0]);
        case (mstep_reg)
            4'd4: pnew = 66'(pos_reg[0]) + step_sh;
            4'd5: pnew = 66'(pos_reg[1]) + step_sh;
            4'd6: pnew = 66'(pos_reg[2]) + step_sh;
            default: ;
        endcase
    end

    // ---------------- divider operands ----------------
    logic signed [32:0] sp_num, sp_den;
    logic [63:0] op_num;
    logic [31:0] op_den;
    logic        op_zero;
    logic [1:0]  sel;
    always_comb
    begin
        op_num  = '0;
        op_den  = '0;
        op_zero = 1'b0;
        sp_num  = '0;
        sp_den  = '0;
        sel     = '0;
        case (op_reg) inside
            [3'd0:3'd2]:
            begin
                sel = op_reg[1:0];
                sp_num = 33'(p_reg[sel]) - 33'(min_reg[sel]);
                sp_den = 33'(max_reg[sel]) - 33'(min_reg[sel]);
                op_num = 64'(sp_num[31:0]) * 64'(n_eff - NW'(1));
                op_den = sp_den[31:0];
                op_zero = (sp_den == 33'sd0);
            end
            [3'd3:3'd5]:
            begin
                sel = 2'(op_reg - 3'd3);
                op_num = 64'(mag(d_reg[sel])) *
                         ((op_reg == 3'd3) ? 64'(LEVEL_SPAN_R) : 64'(LEVEL_SPAN_GB));
                op_den = rate_reg[sel];
                op_zero = (op_den == 32'd0);
            end
            default: ;
        endcase
    end

    logic [32:0] trial;
    logic        mul_last, div_last_op, div_last_bit;
    assign trial        = {rem_reg[31:0], num_reg[63]} - {1'b0, den_reg};
    assign mul_last     = (mstep_reg == 4'(MUL_STEPS));
    assign div_last_bit = (bit_reg == 6'd63);
    assign div_last_op  = (op_reg == 3'd5);
    assign status       = {mul_last, div_last_op, div_last_bit};

    // ---------------- sequential datapath ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg   <= 20'd10486;
            decay_reg  <= 20'd1048541;
            led_reg    <= 11'd256;
            startx_reg <= 32'sd605395;
            starty_reg <= 32'sd605395;
            startz_reg <= 32'sd605395;
            for (int i = 0; i < 3; i++)
            begin
                pos_reg[i]  <= 32'sd605395;
                min_reg[i]  <= '0;
                max_reg[i]  <= '0;
                rate_reg[i] <= '0;
            end
            first_reg <= 1'b1;
            mstep_reg <= '0;
            op_reg    <= '0;
            bit_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_STEP_SIZE:  step_reg  <= cfg_data[19:0];
                    REG_SLOW_DECAY: decay_reg <= cfg_data[19:0];
                    REG_LED_COUNT:  led_reg   <= cfg_data[10:0];
                    REG_START_X:
                    begin
                        startx_reg <= cfg_data;
                        if (first_reg) pos_reg[0] <= cfg_data;
                    end
                    REG_START_Y:
                    begin
                        starty_reg <= cfg_data;
                        if (first_reg) pos_reg[1] <= cfg_data;
                    end
                    REG_START_Z:
                    begin
                        startz_reg <= cfg_data;
                        if (first_reg) pos_reg[2] <= cfg_data;
                    end
                    default: ;
                endcase
            end
            if (cmd.start)
            begin
                mstep_reg <= '0;
                op_reg    <= '0;
            end
            if (cmd.mul_step)
            begin
                mstep_reg <= mstep_reg + 4'd1;
                // step k uses product registered at step k-1
                case (mstep_reg)
                    4'd1: xz_reg <= prod_reg >>> FRAC_BITS;
                    4'd4: begin p_reg[0] <= clip(pnew); end
                    4'd5: begin p_reg[1] <= clip(pnew); end
                    4'd6: begin p_reg[2] <= clip(pnew); end
                    4'd7:  lo_reg[0] <= 32'(prod_reg >>> STEP_FRAC);
                    4'd8:  lo_reg[1] <= 32'(prod_reg >>> STEP_FRAC);
                    4'd9:  lo_reg[2] <= 32'(prod_reg >>> STEP_FRAC);
                    4'd10: hi_reg[0] <= 32'(prod_reg >>> STEP_FRAC);
                    4'd11: hi_reg[1] <= 32'(prod_reg >>> STEP_FRAC);
                    4'd12: hi_reg[2] <= 32'(prod_reg >>> STEP_FRAC);
                    4'd13: r_reg[0]  <= 32'(prod_reg >>> STEP_FRAC);
                    4'd14: r_reg[1]  <= 32'(prod_reg >>> STEP_FRAC);
                    4'd15: r_reg[2]  <= 32'(prod_reg >>> STEP_FRAC);
                    default: ;
                endcase
                if (mstep_reg == 4'd2)
                begin
                    d_reg[0] <= clip(dx_sum);
                    d_reg[1] <= clip(dy_sum);
                    d_reg[2] <= clip(dz_sum);
                end
                if (mstep_reg == 4'd15)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        if (first_reg)
                        begin
                            min_reg[i]  <= p_reg[i];
                            max_reg[i]  <= p_reg[i];
                            rate_reg[i] <= mag(d_reg[i]);
                        end
                        else
                        begin
                            min_reg[i] <= (lo_reg[i] < p_reg[i]) ? lo_reg[i] : p_reg[i];
                            max_reg[i] <= (hi_reg[i] > p_reg[i]) ? hi_reg[i] : p_reg[i];
                            rate_reg[i] <= (i == 2 ? (32'(prod_reg >>> STEP_FRAC) > mag(d_reg[2]))
                                : (r_reg[i] > mag(d_reg[i]))) ?
                                (i == 2 ? 32'(prod_reg >>> STEP_FRAC) : r_reg[i]) : mag(d_reg[i]);
                        end
                        pos_reg[i] <= p_reg[i];
                    end
                    first_reg <= 1'b0;
                end
            end
            if (cmd.div_start)
                bit_reg <= '0;
            if (cmd.div_step)
            begin
                bit_reg <= bit_reg + 6'd1;
                if (status.div_last_bit)
                    op_reg <= op_reg + 3'd1;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            u_reg   <= forcing;
            sat_reg <= 1'b0;
        end
        if (cmd.mul_step)
        begin
            prod_reg <= 64'(mprod);
            if (mstep_reg == 4'd2)
                sat_reg <= sat_reg | ovf(dx_sum) | ovf(dy_sum) | ovf(dz_sum);
            if (mstep_reg == 4'd4 || mstep_reg == 4'd5 || mstep_reg == 4'd6)
                sat_reg <= sat_reg | ovf(pnew);
        end
        if (cmd.div_start)
        begin
            num_reg <= op_num;
            den_reg <= op_den;
            rem_reg <= '0;
        end
        if (cmd.div_step)
        begin
            if (!trial[32])
            begin
                rem_reg <= trial;
                num_reg <= {num_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[31:0], num_reg[63]};
                num_reg <= {num_reg[62:0], 1'b0};
            end
            if (cmd.div_store)
            begin
                if (op_zero)
                    q_reg[op_reg] <= (op_reg < 3'd3) ? 16'd0 : 16'(LEVEL_LOW);
                else if (op_reg < 3'd3)
                    q_reg[op_reg] <= {6'd0, num_reg[8:0], !trial[32]};
                else
                    q_reg[op_reg] <= 16'(LEVEL_LOW) + {num_reg[14:0], !trial[32]};
            end
        end
    end

    assign red_index   = q_reg[0][9:0];
    assign green_index = q_reg[1][9:0];
    assign blue_index  = q_reg[2][9:0];
    assign red_level   = q_reg[3];
    assign green_level = q_reg[4];
    assign blue_level  = q_reg[5];
    assign saturated   = sat_reg;
endmodule
`default_nettype wire

/* tb/sv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the attractor step core: forcing values and
// register writes are driven with random idling on both sides, and every
// result transaction is compared with a bit-accurate Euler-step predictor.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import msa_pkg::*;

    localparam longint I32_MAX = 64'sd2147483647;
    localparam longint I32_MIN = -64'sd2147483648;
    localparam int     N_LEDS_MAX = 1024;
    localparam int     FRAC_SHIFT = 20;

    typedef struct packed {
        logic [9:0]  red_index;
        logic [9:0]  green_index;
        logic [9:0]  blue_index;
        logic [15:0] red_level;
        logic [15:0] green_level;
        logic [15:0] blue_level;
        logic        saturated;
    } led_frame_t;

    typedef struct packed {
        reg_index_t  index;
        logic [31:0] data;
    } reg_write_t;

    logic clk;
    logic rst_n;

    msa_in_if  in_ch ();
    msa_out_if out_ch ();
    msa_cfg_if cfg_ch ();

    multiscroll_attractor_euler_step_core u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    // predictor state
    longint dt_q, decay_q, leds_q;
    longint org_x, org_y, org_z;
    longint px, py, pz;
    longint trk_lo[3], trk_hi[3], trk_rate[3];
    bit     seeding;

    logic signed [24:0] forcing_q[$];
    reg_write_t         reg_q[$];
    led_frame_t         frame_q[$];
    int                 n_fail;
    bit                 calm;

    function automatic longint clip32(longint v, ref bit sat);
        if (v > I32_MAX) begin sat = 1; return I32_MAX; end
        if (v < I32_MIN) begin sat = 1; return I32_MIN; end
        return v;
    endfunction

    function automatic longint magn(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic logic [9:0] led_pos(longint p, longint lo, longint hi, longint n);
        longint q;
        if (hi == lo) return 10'd0;
        q = ((p - lo) * (n - 1)) / (hi - lo);
        return q[9:0];
    endfunction

    function automatic logic [15:0] glow(longint d, longint range, longint width);
        longint q;
        if (range == 0) return 16'(LEVEL_LOW);
        q = LEVEL_LOW + (d * width) / range;
        return q[15:0];
    endfunction

    function automatic void apply_write(reg_write_t w);
        case (w.index)
            REG_STEP_SIZE:  dt_q = longint'(w.data[19:0]);
            REG_SLOW_DECAY: decay_q = longint'(w.data[19:0]);
            REG_LED_COUNT:  leds_q = longint'(w.data[10:0]);
            REG_START_X: begin org_x = longint'($signed(w.data)); if (seeding) px = org_x; end
            REG_START_Y: begin org_y = longint'($signed(w.data)); if (seeding) py = org_y; end
            REG_START_Z: begin org_z = longint'($signed(w.data)); if (seeding) pz = org_z; end
            default: ;
        endcase
    endfunction

    function automatic led_frame_t euler_tick(logic signed [24:0] u_in);
        led_frame_t f;
        bit     sat;
        longint u, n;
        longint d[3], p[3];
        longint lo, hi, r, m;
        sat = 0;
        u = longint'(u_in);
        d[0] = clip32(36 * (py - px), sat);
        d[1] = clip32(px - ((px * pz) >>> FRAC_SHIFT) + 20 * py + u, sat);
        d[2] = clip32(((px * py) >>> FRAC_SHIFT) - 3 * pz, sat);
        px = clip32(px + ((d[0] * dt_q) >>> STEP_FRAC), sat);
        py = clip32(py + ((d[1] * dt_q) >>> STEP_FRAC), sat);
        pz = clip32(pz + ((d[2] * dt_q) >>> STEP_FRAC), sat);
        p[0] = px; p[1] = py; p[2] = pz;
        for (int i = 0; i < 3; i++) begin
            m = magn(d[i]);
            if (seeding) begin
                trk_lo[i] = p[i]; trk_hi[i] = p[i]; trk_rate[i] = m;
            end else begin
                lo = (trk_lo[i] * decay_q) >>> STEP_FRAC;
                hi = (trk_hi[i] * decay_q) >>> STEP_FRAC;
                r  = (trk_rate[i] * decay_q) >>> STEP_FRAC;
                trk_lo[i] = (lo < p[i]) ? lo : p[i];
                trk_hi[i] = (hi > p[i]) ? hi : p[i];
                trk_rate[i] = (r > m) ? r : m;
            end
        end
        seeding = 0;
        n = leds_q;
        if (n < 1) n = 1;
        if (n > N_LEDS_MAX) n = N_LEDS_MAX;
        f.red_index   = led_pos(p[0], trk_lo[0], trk_hi[0], n);
        f.green_index = led_pos(p[1], trk_lo[1], trk_hi[1], n);
        f.blue_index  = led_pos(p[2], trk_lo[2], trk_hi[2], n);
        f.red_level   = glow(magn(d[0]), trk_rate[0], LEVEL_SPAN_R);
        f.green_level = glow(magn(d[1]), trk_rate[1], LEVEL_SPAN_GB);
        f.blue_level  = glow(magn(d[2]), trk_rate[2], LEVEL_SPAN_GB);
        f.saturated   = sat;
        return f;
    endfunction

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // forcing driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_ch.valid   <= 1'b0;
            in_ch.forcing <= '0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (forcing_q.size() > 0 && (calm || $urandom_range(99) >= 13)) begin
                in_ch.forcing <= forcing_q.pop_front();
                in_ch.valid   <= 1'b1;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // register write driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_ch.valid <= 1'b0;
            cfg_ch.index <= REG_STEP_SIZE;
            cfg_ch.data  <= '0;
        end else if (!cfg_ch.valid || cfg_ch.ready) begin
            if (reg_q.size() > 0 && (calm || $urandom_range(99) >= 13)) begin
                cfg_ch.index <= reg_q[0].index;
                cfg_ch.data  <= reg_q[0].data;
                cfg_ch.valid <= 1'b1;
                void'(reg_q.pop_front());
            end else begin
                cfg_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= calm || ($urandom_range(99) >= 13);
    end

    // monitor: predict on accepted transactions, check results
    always @(posedge clk)
    begin
        led_frame_t want;
        reg_write_t w;
        if (rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                w.index = reg_index_t'(cfg_ch.index);
                w.data  = cfg_ch.data;
                apply_write(w);
            end
            if (in_ch.valid && in_ch.ready)
                frame_q.push_back(euler_tick(in_ch.forcing));
            if (out_ch.valid && out_ch.ready) begin
                if (frame_q.size() == 0) begin
                    $error("result transaction with nothing expected");
                    n_fail++;
                end else begin
                    want = frame_q.pop_front();
                    if (out_ch.red_index !== want.red_index) begin
                        $error("red_index exp %0d got %0d", want.red_index, out_ch.red_index);
                        n_fail++;
                    end
                    if (out_ch.green_index !== want.green_index) begin
                        $error("green_index exp %0d got %0d", want.green_index,
                            out_ch.green_index);
                        n_fail++;
                    end
                    if (out_ch.blue_index !== want.blue_index) begin
                        $error("blue_index exp %0d got %0d", want.blue_index, out_ch.blue_index);
                        n_fail++;
                    end
                    if (out_ch.red_level !== want.red_level) begin
                        $error("red_level exp %0d got %0d", want.red_level, out_ch.red_level);
                        n_fail++;
                    end
                    if (out_ch.green_level !== want.green_level) begin
                        $error("green_level exp %0d got %0d", want.green_level,
                            out_ch.green_level);
                        n_fail++;
                    end
                    if (out_ch.blue_level !== want.blue_level) begin
                        $error("blue_level exp %0d got %0d", want.blue_level, out_ch.blue_level);
                        n_fail++;
                    end
                    if (out_ch.saturated !== want.saturated) begin
                        $error("saturated exp %0d got %0d", want.saturated, out_ch.saturated);
                        n_fail++;
                    end
                end
            end
        end
    end

    task automatic write_reg(reg_index_t idx, logic [31:0] val);
        reg_write_t w;
        w.index = idx;
        w.data  = val;
        reg_q.push_back(w);
    endtask

    task automatic drain();
        while (reg_q.size() > 0 || cfg_ch.valid || forcing_q.size() > 0 || in_ch.valid
            || frame_q.size() > 0)
            @(posedge clk);
    endtask

    function automatic logic signed [24:0] rand_forcing();
        return 25'(int'($urandom_range(31457280)) - 15728640);
    endfunction

    function automatic logic [31:0] small_start();
        return 32'(int'($urandom_range(8388608)) - 4194304);
    endfunction

    initial
    begin
        logic signed [24:0] edge_vals[6];
        logic [31:0] dt_set[6];
        logic [31:0] decay_set[6];
        logic [31:0] led_set[6];
        int          n_items;
        n_fail = 0;
        calm = 0;
        dt_q = 10486; decay_q = 1048541; leds_q = 256;
        org_x = 605395; org_y = 605395; org_z = 605395;
        px = org_x; py = org_y; pz = org_z;
        for (int i = 0; i < 3; i++) begin
            trk_lo[i] = 0; trk_hi[i] = 0; trk_rate[i] = 0;
        end
        seeding = 1;
        rst_n = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // start position written before the first tick reloads the state
        write_reg(REG_START_X, small_start());
        write_reg(REG_START_Y, small_start());
        write_reg(REG_START_Z, small_start());
        drain();

        // directed: forcing extremes and sign bit patterns, default registers
        edge_vals = '{25'sd15728640, -25'sd15728640, 25'sd0, 25'sd1, -25'sd1, 25'sd8388608};
        foreach (edge_vals[i]) forcing_q.push_back(edge_vals[i]);
        drain();
        // zero step: state frozen; LED count zero clamps to a single LED
        write_reg(REG_STEP_SIZE, 32'd0);
        write_reg(REG_LED_COUNT, 32'd0);
        drain();
        for (int i = 0; i < 4; i++) forcing_q.push_back(rand_forcing());
        drain();
        // no decay memory, single LED, then out-of-range led count
        write_reg(REG_SLOW_DECAY, 32'd0);
        write_reg(REG_STEP_SIZE, 32'd10486);
        write_reg(REG_LED_COUNT, 32'd1);
        drain();
        for (int i = 0; i < 4; i++) forcing_q.push_back(rand_forcing());
        drain();
        write_reg(REG_LED_COUNT, 32'd2047);
        write_reg(REG_SLOW_DECAY, 32'd1048575);
        write_reg(REG_START_X, 32'h8000_0000);
        write_reg(REG_START_Y, 32'h7fff_ffff);
        write_reg(REG_START_Z, 32'hffff_ffff);
        drain();
        for (int i = 0; i < 4; i++) forcing_q.push_back(rand_forcing());
        drain();

        // random phases; largest step last since it drives the state to the rails
        dt_set    = '{32'd10486, 32'd2000, 32'd52428, 32'd1, 32'd200000, 32'd1048575};
        decay_set = '{32'd1048541, 32'd1048575, 32'd900000, 32'd0, 32'd1048000, 32'd524288};
        led_set   = '{32'd256, 32'd1024, 32'd7, 32'd0, 32'd1025, 32'd2};
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(REG_STEP_SIZE, dt_set[ph]);
            write_reg(REG_SLOW_DECAY, decay_set[ph]);
            write_reg(REG_LED_COUNT, led_set[ph]);
            write_reg(REG_START_X, $urandom);
            write_reg(REG_START_Y, $urandom);
            write_reg(REG_START_Z, $urandom);
            drain();
            calm = (ph == 2);
            n_items = 140;
            for (int i = 0; i < n_items; i++)
                forcing_q.push_back(rand_forcing());
            drain();
            calm = 0;
        end

        repeat (50) @(posedge clk);
        if (n_fail == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end
endmodule
